// ----- hdl/nts_pkg.sv -----
// ----------------------------------------------------------------------------
// nts_pkg: shared types and constants for the nearest timestamp search
// table depth, item layouts, probe result bundle and sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package nts_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int TS_W   = 32;
  localparam int POS_W  = 10;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [TS_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [TS_W-1:0]  found_time;
    logic             exact;
    logic             empty_res;
    logic             rejected;
  } rsp_t;

  // outcome of comparing one probed entry against the key
  typedef struct packed {
    logic            closer;
    logic            equal;
    logic            below;
    logic [TS_W-1:0] gap;
  } probe_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_LD0,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/nts_ram.sv -----
// ----------------------------------------------------------------------------
// nts_ram: generic single write, single read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module nts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/nts_probe.sv -----
// ----------------------------------------------------------------------------
// nts_probe: shared compare unit of the search
// absolute distance of one entry to the key and its ordering against it
// ----------------------------------------------------------------------------
`default_nettype none

module nts_probe
  import nts_pkg::*;
(
  input  wire logic [TS_W-1:0] entry,
  input  wire logic [TS_W-1:0] key,
  input  wire logic [TS_W-1:0] best_gap,
  output probe_res_t           res
);

  always_comb begin
    res.below  = entry < key;
    res.equal  = entry == key;
    res.gap    = res.below ? (key - entry) : (entry - key);
    // strict compare, an earlier candidate keeps a tie
    res.closer = res.gap < best_gap;
  end

endmodule

`default_nettype wire

// ----- hdl/nearest_timestamp_search.sv -----
// ----------------------------------------------------------------------------
// nearest_timestamp_search: timestamp table with nearest-match binary search
// append, clear and nearest query on a table of nondecreasing timestamps
// ----------------------------------------------------------------------------
// Each item returns exactly one result item. An append writes the key at the
// next free slot in the accept cycle (or flags rejected when the table is
// full) and a clear empties the table; both go from the accept cycle through
// S_DONE to a loaded result register. A query first reads entry 0 as the
// starting candidate, then runs the binary search one probe at a time through
// the single ram read port and the shared compare unit, with at most
// ceil(log2(count+1)) probes; a probe that hits the key ends the search. Each
// probe puts the read address out in S_PROBE and compares the registered
// read data in S_CMP. A query on an empty table returns empty_res without a
// search. A held output register stalls the sequencer in S_DONE. req_stall
// is high during reset and while an item is in work; a finished result waits
// in the output register while the next item is already being accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_timestamp_search
  import nts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  // sequencer state
  state_t state, state_next;

  // fill level of the table
  logic [CNT_W-1:0] count, count_next;

  // search window [lo, hi_x), hi_x exclusive so the window never goes negative
  logic [CNT_W-1:0] lo, lo_next;
  logic [CNT_W-1:0] hi_x, hi_x_next;
  logic [ADDR_W-1:0] mid, mid_next;

  // latched key and best candidate so far
  logic [TS_W-1:0]   key_r, key_r_next;
  logic [ADDR_W-1:0] best, best_next;
  logic [TS_W-1:0]   best_time, best_time_next;
  logic [TS_W-1:0]   best_gap, best_gap_next;

  // pending result, moved to the output register when it is free
  rsp_t res, res_next;
  logic rsp_valid_next;
  rsp_t rsp_next;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [TS_W-1:0]   ram_rdata;

  probe_res_t pr;

  logic              accept;
  logic [CNT_W:0]    mid_sum;
  logic              out_free;

  assign accept    = req_valid && !req_stall;
  assign req_stall = rst || (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // midpoint of the inclusive window [lo, hi_x - 1]
  assign mid_sum = {1'b0, lo} + {1'b0, hi_x} - {{CNT_W{1'b0}}, 1'b1};

  // append writes straight from the request in the accept cycle
  assign ram_we    = accept && (req.opcode == OP_APPEND) && (count < CNT_W'(DEPTH));
  assign ram_waddr = count[ADDR_W-1:0];

  nts_ram #(
    .WIDTH (TS_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.key),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nts_probe u_probe (
    .entry    (ram_rdata),
    .key      (key_r),
    .best_gap (best_gap),
    .res      (pr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
    lo        <= lo_next;
    hi_x      <= hi_x_next;
    mid       <= mid_next;
    key_r     <= key_r_next;
    best      <= best_next;
    best_time <= best_time_next;
    best_gap  <= best_gap_next;
    res       <= res_next;
    rsp       <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    lo_next        = lo;
    hi_x_next      = hi_x;
    mid_next       = mid;
    key_r_next     = key_r;
    best_next      = best;
    best_time_next = best_time;
    best_gap_next  = best_gap;
    res_next       = res;
    rsp_next       = rsp;
    ram_raddr      = mid;

    // output register drains independently of the sequencer
    rsp_valid_next = rsp_valid && rsp_stall;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          key_r_next = req.key;
          res_next   = '0;
          state_next = S_DONE;
          unique case (opcode_t'(req.opcode))
            OP_APPEND: begin
              if (count < CNT_W'(DEPTH)) begin
                count_next = count + CNT_W'(1);
              end else begin
                res_next.rejected = 1'b1;
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_QUERY: begin
              if (count == '0) begin
                res_next.empty_res = 1'b1;
              end else begin
                lo_next    = '0;
                hi_x_next  = count;
                state_next = S_RD0;
              end
            end
            OP_NONE: begin
              // unused code: no table change, zero result
            end
          endcase
        end
      end

      S_RD0: begin
        // entry 0 is the starting candidate
        ram_raddr  = '0;
        state_next = S_LD0;
      end

      S_LD0: begin
        best_next      = '0;
        best_time_next = ram_rdata;
        best_gap_next  = pr.gap;
        state_next     = S_PROBE;
      end

      S_PROBE: begin
        if (lo < hi_x) begin
          ram_raddr  = mid_sum[ADDR_W:1];
          mid_next   = mid_sum[ADDR_W:1];
          state_next = S_CMP;
        end else begin
          res_next.position   = POS_W'(best);
          res_next.found_time = best_time;
          state_next          = S_DONE;
        end
      end

      S_CMP: begin
        if (pr.closer) begin
          best_next      = mid;
          best_time_next = ram_rdata;
          best_gap_next  = pr.gap;
        end
        priority if (pr.equal) begin
          res_next.position   = POS_W'(mid);
          res_next.found_time = ram_rdata;
          res_next.exact      = 1'b1;
          state_next          = S_DONE;
        end else if (pr.below) begin
          lo_next    = CNT_W'(mid) + CNT_W'(1);
          state_next = S_PROBE;
        end else begin
          hi_x_next  = CNT_W'(mid);
          state_next = S_PROBE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // table never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond table depth");

  // a probe is only issued on a nonempty window
  a_window: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> lo < hi_x && hi_x <= count)
    else $error("probe outside search window");

  // an exact hit carries the key itself
  a_exact_time: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && res.exact |-> res.found_time == key_r && !res.empty_res)
    else $error("exact result with mismatching time");

  // an empty-table result only arises from an empty table
  a_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && res.empty_res |-> count == '0)
    else $error("empty result on filled table");

endmodule

`default_nettype wire
